[rtl/qvr_pkg.sv]
// Shared constants and types for the quaternion vector rotator.
`default_nettype none
package qvr_pkg;

  // Quaternion components are signed Q2.14 words.
  localparam int QUAT_W = 16;
  // A product of two quaternion components.
  localparam int PQ_W   = 2 * QUAT_W;
  // A rotation matrix coefficient: sum of four products, or twice a sum of two.
  localparam int COEF_W = PQ_W + 2;

  localparam int DEF_VEC_WIDTH = 24;
  localparam int DEF_FRAC_BITS = 14;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_QUAT_W = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_X = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

  // Scalar part resets to 1.0 in Q2.14.
  localparam logic [QUAT_W-1:0] QUAT_W_RESET = 16'h4000;

  // Cycles the coefficient pipeline needs before new coefficients are usable.
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

  typedef logic [QUAT_W-1:0]              quat_t;
  typedef logic [2:0][COEF_W-1:0]         coef_row_t;
  typedef logic [2:0][2:0][COEF_W-1:0]    coef_mat_t;

  // Per-stage advance enables of the datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage
`default_nettype wire

[rtl/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotator: registers, handshake and datapath.
//
// Rotates each input vector by the quaternion held in four 16-bit Q2.14
// registers (APB-style port, byte addresses 0, 4, 8, 12 for w, x, y, z).
// The result is q * (0, v) * conj(q), rounded half up and saturated; the
// quaternion is not normalized, so |q|^2 scales the output.
// Input beats arrive on in_valid / in_stall, results leave on out_valid /
// out_stall; a beat moves at an edge where valid is high and stall is low.
// The datapath has four register stages: the multiply, two add stages and
// the round-and-saturate stage; out_valid is the valid bit of the last one.
// One beat per cycle is sustained while out_stall is low and no register
// write is settling. A stalled stage holds; earlier stages fill any bubbles
// in front of it, and in_stall rises when stage one cannot move or while settling.
// The rotation matrix is computed from the registers in two stages, so after
// reset and after each register write in_stall stays high until both stages
// are updated. Reset restores the identity rotation and empties the pipeline.
`default_nettype none
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::DEF_FRAC_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [qvr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire  [qvr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [qvr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire signed [VEC_WIDTH-1:0]          in_vec_x,
  input  wire signed [VEC_WIDTH-1:0]          in_vec_y,
  input  wire signed [VEC_WIDTH-1:0]          in_vec_z,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [VEC_WIDTH-1:0]         out_rot_x,
  output logic signed [VEC_WIDTH-1:0]         out_rot_y,
  output logic signed [VEC_WIDTH-1:0]         out_rot_z,
  output logic                                out_saturated
);

  localparam int QW = qvr_pkg::QUAT_W;
  localparam int DW = qvr_pkg::CFG_DATA_W;

  qvr_pkg::quat_t quat_w_r, quat_x_r, quat_y_r, quat_z_r;
  logic [qvr_pkg::SETTLE_W-1:0] settle_r;
  logic [qvr_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;
  logic in_accept;
  logic v1_r, v2_r, v3_r, v4_r;
  qvr_pkg::stage_en_t en;
  qvr_pkg::coef_mat_t coef;
  logic sat_x, sat_y, sat_z;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[qvr_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r <= qvr_pkg::QUAT_W_RESET;
      quat_x_r <= '0;
      quat_y_r <= '0;
      quat_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        qvr_pkg::REG_QUAT_W: quat_w_r <= pwdata[QW-1:0];
        qvr_pkg::REG_QUAT_X: quat_x_r <= pwdata[QW-1:0];
        qvr_pkg::REG_QUAT_Y: quat_y_r <= pwdata[QW-1:0];
        qvr_pkg::REG_QUAT_Z: quat_z_r <= pwdata[QW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qvr_pkg::REG_QUAT_W: prdata = {{(DW-QW){quat_w_r[QW-1]}}, quat_w_r};
      qvr_pkg::REG_QUAT_X: prdata = {{(DW-QW){quat_x_r[QW-1]}}, quat_x_r};
      qvr_pkg::REG_QUAT_Y: prdata = {{(DW-QW){quat_y_r[QW-1]}}, quat_y_r};
      qvr_pkg::REG_QUAT_Z: prdata = {{(DW-QW){quat_z_r[QW-1]}}, quat_z_r};
    endcase
  end

  // Hold off input beats until the coefficients reflect the registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= qvr_pkg::SETTLE_CYCLES;
    end else if (cfg_wr) begin
      settle_r <= qvr_pkg::SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  assign en.s4 = !v4_r || !out_stall;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;

  assign in_stall  = !en.s1 || (settle_r != '0);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_accept;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  qvr_matrix u_matrix (
    .clk    (clk),
    .quat_w (quat_w_r),
    .quat_x (quat_x_r),
    .quat_y (quat_y_r),
    .quat_z (quat_z_r),
    .coef   (coef)
  );

  qvr_row #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_x (
    .clk   (clk),
    .en    (en),
    .coef  (coef[0]),
    .vec_x (in_vec_x),
    .vec_y (in_vec_y),
    .vec_z (in_vec_z),
    .rot   (out_rot_x),
    .sat   (sat_x)
  );

  qvr_row #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_y (
    .clk   (clk),
    .en    (en),
    .coef  (coef[1]),
    .vec_x (in_vec_x),
    .vec_y (in_vec_y),
    .vec_z (in_vec_z),
    .rot   (out_rot_y),
    .sat   (sat_y)
  );

  qvr_row #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_z (
    .clk   (clk),
    .en    (en),
    .coef  (coef[2]),
    .vec_x (in_vec_x),
    .vec_y (in_vec_y),
    .vec_z (in_vec_z),
    .rot   (out_rot_z),
    .sat   (sat_z)
  );

  assign out_valid     = v4_r;
  assign out_saturated = sat_x || sat_y || sat_z;

endmodule
`default_nettype wire

[rtl/qvr_matrix.sv]
// Rotation matrix coefficients derived from the quaternion registers.
`default_nettype none
module qvr_matrix (
  input  wire                  clk,
  input  qvr_pkg::quat_t       quat_w,
  input  qvr_pkg::quat_t       quat_x,
  input  qvr_pkg::quat_t       quat_y,
  input  qvr_pkg::quat_t       quat_z,
  output qvr_pkg::coef_mat_t   coef
);

  localparam int PW = qvr_pkg::PQ_W;
  localparam int CW = qvr_pkg::COEF_W;

  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r;
  logic signed [PW-1:0] xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  qvr_pkg::coef_mat_t   coef_r;
  qvr_pkg::coef_mat_t   coef_nxt;

  logic signed [qvr_pkg::QUAT_W-1:0] qw, qx, qy, qz;
  assign qw = $signed(quat_w);
  assign qx = $signed(quat_x);
  assign qy = $signed(quat_y);
  assign qz = $signed(quat_z);

  // The matrix runs freely; the top level holds off input beats until it settles.
  always_ff @(posedge clk) begin
    ww_r <= qw * qw;
    xx_r <= qx * qx;
    yy_r <= qy * qy;
    zz_r <= qz * qz;
    xy_r <= qx * qy;
    wz_r <= qw * qz;
    xz_r <= qx * qz;
    wy_r <= qw * qy;
    yz_r <= qy * qz;
    wx_r <= qw * qx;
    coef_r <= coef_nxt;
  end

  always_comb begin
    logic signed [CW-1:0] e_ww, e_xx, e_yy, e_zz;
    logic signed [CW-1:0] e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
    e_ww = CW'(ww_r);
    e_xx = CW'(xx_r);
    e_yy = CW'(yy_r);
    e_zz = CW'(zz_r);
    e_xy = CW'(xy_r);
    e_wz = CW'(wz_r);
    e_xz = CW'(xz_r);
    e_wy = CW'(wy_r);
    e_yz = CW'(yz_r);
    e_wx = CW'(wx_r);
    coef_nxt[0][0] = e_ww + e_xx - e_yy - e_zz;
    coef_nxt[0][1] = (e_xy - e_wz) <<< 1;
    coef_nxt[0][2] = (e_xz + e_wy) <<< 1;
    coef_nxt[1][0] = (e_xy + e_wz) <<< 1;
    coef_nxt[1][1] = e_ww - e_xx + e_yy - e_zz;
    coef_nxt[1][2] = (e_yz - e_wx) <<< 1;
    coef_nxt[2][0] = (e_xz - e_wy) <<< 1;
    coef_nxt[2][1] = (e_yz + e_wx) <<< 1;
    coef_nxt[2][2] = e_ww - e_xx - e_yy + e_zz;
  end

  assign coef = coef_r;

endmodule
`default_nettype wire

[rtl/qvr_row.sv]
// One output component: dot product, rounding and saturation over four stages.
`default_nettype none
module qvr_row #(
  parameter int VEC_WIDTH = qvr_pkg::DEF_VEC_WIDTH,
  parameter int FRAC_BITS = qvr_pkg::DEF_FRAC_BITS
) (
  input  wire                         clk,
  input  qvr_pkg::stage_en_t          en,
  input  qvr_pkg::coef_row_t          coef,
  input  wire signed [VEC_WIDTH-1:0]  vec_x,
  input  wire signed [VEC_WIDTH-1:0]  vec_y,
  input  wire signed [VEC_WIDTH-1:0]  vec_z,
  output logic signed [VEC_WIDTH-1:0] rot,
  output logic                        sat
);

  localparam int CW    = qvr_pkg::COEF_W;
  localparam int PW    = CW + VEC_WIDTH;
  localparam int ACC_W = PW + 2;
  localparam int SHIFT = 2 * FRAC_BITS;
  localparam int SW    = ACC_W - SHIFT;
  localparam int TOP_W = SW - VEC_WIDTH + 1;

  localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic signed [CW-1:0]    c0, c1, c2;
  logic signed [PW-1:0]    p0_nxt, p1_nxt, p2_nxt;
  logic signed [PW-1:0]    p0_r, p1_r, p2_r;
  logic signed [ACC_W-1:0] sa_r, sb_r, acc_r;
  logic signed [VEC_WIDTH-1:0] rot_r, rot_nxt;
  logic                    sat_r, sat_nxt;
  logic [SW-1:0]           sh;
  logic [TOP_W-1:0]        top;

  assign c0 = $signed(coef[0]);
  assign c1 = $signed(coef[1]);
  assign c2 = $signed(coef[2]);

  assign p0_nxt = c0 * vec_x;
  assign p1_nxt = c1 * vec_y;
  assign p2_nxt = c2 * vec_z;

  // Bits above the output width must all match the sign, else the value is clipped.
  assign sh  = acc_r[ACC_W-1:SHIFT];
  assign top = sh[SW-1:VEC_WIDTH-1];

  always_comb begin
    sat_nxt = !((&top) || !(|top));
    if (sat_nxt) begin
      rot_nxt = sh[SW-1] ? VMIN : VMAX;
    end else begin
      rot_nxt = sh[VEC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (en.s2) begin
      sa_r <= ACC_W'(p0_r) + ACC_W'(p1_r);
      sb_r <= ACC_W'(p2_r) + $signed(HALF);
    end
    if (en.s3) begin
      acc_r <= sa_r + sb_r;
    end
    if (en.s4) begin
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign rot = rot_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

[dv/tb_quaternion_vector_rotate.sv]
// Self-checking testbench for the quaternion vector rotator.
`timescale 1ns / 1ps
module tb_quaternion_vector_rotate;

  localparam int VEC_W       = qvr_pkg::DEF_VEC_WIDTH;
  localparam int FRAC        = qvr_pkg::DEF_FRAC_BITS;
  localparam int ROUND_SHIFT = 2 * FRAC;
  localparam int LATENCY     = 4;
  localparam int IDLE_PCT    = 21;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASES      = 9;
  localparam int PHASE_BEATS = 200;
  localparam int PRINT_MAX   = 100;

  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (ROUND_SHIFT - 1);
  localparam logic signed [127:0] WIDE_MAX   = (128'sd1 <<< (VEC_W - 1)) - 128'sd1;
  localparam logic signed [127:0] WIDE_MIN   = -(128'sd1 <<< (VEC_W - 1));
  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [qvr_pkg::QUAT_W-1:0] w;
    logic signed [qvr_pkg::QUAT_W-1:0] x;
    logic signed [qvr_pkg::QUAT_W-1:0] y;
    logic signed [qvr_pkg::QUAT_W-1:0] z;
  } quaternion_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
    logic                    sat;
  } rot_t;

  typedef struct packed {
    quaternion_t q;
    vec_t        v;
    bit          typed;
    rot_t        want;
  } row_t;

  localparam quaternion_t QUAT_IDENTITY = '{16384, 0, 0, 0};

  // Rows with typed results are the ones whose answer is plain: the identity,
  // a pure scale by four, half turns about an axis and the zero quaternion.
  row_t directed_rows [20] = '{
    '{QUAT_IDENTITY, '{0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}},
    '{QUAT_IDENTITY, '{8388607, -8388608, 1}, 1'b1, '{8388607, -8388608, 1, 1'b0}},
    '{QUAT_IDENTITY, '{-1, 1, -8388608}, 1'b1, '{-1, 1, -8388608, 1'b0}},
    '{QUAT_IDENTITY, '{123456, -654321, 42}, 1'b0, '0},
    '{'{-32768, 0, 0, 0}, '{8388607, -8388608, 0}, 1'b1, '{8388607, -8388608, 0, 1'b1}},
    '{'{-32768, 0, 0, 0}, '{1, -1, 2097151}, 1'b1, '{4, -4, 8388604, 1'b0}},
    '{'{0, 16384, 0, 0}, '{5, -8388608, 8388607}, 1'b1, '{5, 8388607, -8388607, 1'b1}},
    '{'{0, 0, 16384, 0}, '{-8388608, 7, -3}, 1'b1, '{8388607, 7, 3, 1'b1}},
    '{'{0, 0, 0, 8192}, '{2, -2, 6}, 1'b0, '0},
    '{'{0, 0, 0, 8192}, '{-6, 1, -2}, 1'b0, '0},
    '{'{11585, 0, 0, 11585}, '{1000, 0, 0}, 1'b0, '0},
    '{'{32767, 32767, 32767, 32767}, '{8388607, 8388607, 8388607}, 1'b0, '0},
    '{'{32767, 32767, 32767, 32767}, '{-8388608, -8388608, -8388608}, 1'b0, '0},
    '{'{-32768, -32768, -32768, -32768}, '{8388607, -8388608, 8388607}, 1'b0, '0},
    '{'{-32768, -32768, -32768, -32768}, '{1, 1, 1}, 1'b0, '0},
    '{'{0, 0, 0, 0}, '{8388607, -8388608, 12345}, 1'b1, '{0, 0, 0, 1'b0}},
    '{'{32767, 0, 0, 0}, '{8388607, -3, 2097152}, 1'b0, '0},
    '{'{8192, -8192, 8192, -8192}, '{3, -5, 7}, 1'b0, '0},
    '{'{-32768, 32767, -32768, 32767}, '{0, 0, -1}, 1'b0, '0},
    '{QUAT_IDENTITY, '{77, -77, 8388607}, 1'b1, '{77, -77, 8388607, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [qvr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [qvr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [qvr_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VEC_W-1:0] in_vec_x = '0;
  logic signed [VEC_W-1:0] in_vec_y = '0;
  logic signed [VEC_W-1:0] in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VEC_W-1:0] out_rot_x;
  logic signed [VEC_W-1:0] out_rot_y;
  logic signed [VEC_W-1:0] out_rot_z;
  logic out_saturated;

  quaternion_t cur_quat = QUAT_IDENTITY;
  rot_t        rot_expected_q [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          idling_on = 1'b1;

  quaternion_vector_rotate dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_saturated(out_saturated)
  );

  always #10 clk = ~clk;

  // Exact rotation matrix times vector, rounded half up and clipped.
  function automatic rot_t rotate_vec(input quaternion_t q, input vec_t v);
    logic signed [127:0] w, x, y, z;
    logic signed [127:0] vin [3];
    logic signed [127:0] m [3][3];
    logic signed [127:0] acc;
    logic signed [VEC_W-1:0] comp [3];
    logic sat;
    rot_t r;
    w = $signed(q.w);
    x = $signed(q.x);
    y = $signed(q.y);
    z = $signed(q.z);
    vin[0] = $signed(v.x);
    vin[1] = $signed(v.y);
    vin[2] = $signed(v.z);
    m[0][0] = w*w + x*x - y*y - z*z;
    m[0][1] = 2 * (x*y - w*z);
    m[0][2] = 2 * (x*z + w*y);
    m[1][0] = 2 * (x*y + w*z);
    m[1][1] = w*w - x*x + y*y - z*z;
    m[1][2] = 2 * (y*z - w*x);
    m[2][0] = 2 * (x*z - w*y);
    m[2][1] = 2 * (y*z + w*x);
    m[2][2] = w*w - x*x - y*y + z*z;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0]*vin[0] + m[i][1]*vin[1] + m[i][2]*vin[2] + ROUND_HALF;
      acc = acc >>> ROUND_SHIFT;
      if (acc > WIDE_MAX) begin
        comp[i] = VEC_MAX;
        sat = 1'b1;
      end else if (acc < WIDE_MIN) begin
        comp[i] = VEC_MIN;
        sat = 1'b1;
      end else begin
        comp[i] = acc[VEC_W-1:0];
      end
    end
    r.x = comp[0];
    r.y = comp[1];
    r.z = comp[2];
    r.sat = sat;
    return r;
  endfunction

  function automatic logic signed [VEC_W-1:0] random_comp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return VEC_W'($urandom);
    if (pick < 90) return VEC_W'(int'($urandom_range(2000)) - 1000);
    case ($urandom_range(3))
      0: return VEC_MAX;
      1: return VEC_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [qvr_pkg::QUAT_W-1:0] random_coef(input bit full);
    if (full) return qvr_pkg::QUAT_W'($urandom);
    return qvr_pkg::QUAT_W'(int'($urandom_range(18000)) - 9000);
  endfunction

  // Each phase holds one quaternion; the first two are the register extremes.
  function automatic quaternion_t phase_quat(input int ph);
    quaternion_t q;
    bit full;
    full = (ph == 4 || ph == 6);
    case (ph)
      0: q = '{32767, 32767, 32767, 32767};
      1: q = '{-32768, -32768, -32768, -32768};
      8: q = QUAT_IDENTITY;
      default: q = '{random_coef(full), random_coef(full), random_coef(full),
                     random_coef(full)};
    endcase
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic queue_expected(input rot_t r);
    rot_expected_q = {rot_expected_q, r};
  endtask

  // Upper data bits are random; only the low 16 bits belong to the register.
  // The bus is left selected so that writes can follow back to back.
  task automatic write_reg(input logic [qvr_pkg::REG_IDX_W-1:0] idx,
                           input logic signed [qvr_pkg::QUAT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      qvr_pkg::REG_QUAT_W: cur_quat.w = value;
      qvr_pkg::REG_QUAT_X: cur_quat.x = value;
      qvr_pkg::REG_QUAT_Y: cur_quat.y = value;
      qvr_pkg::REG_QUAT_Z: cur_quat.z = value;
      default: ;
    endcase
  endtask

  task automatic set_quat(input quaternion_t q);
    write_reg(qvr_pkg::REG_QUAT_W, q.w);
    write_reg(qvr_pkg::REG_QUAT_X, q.x);
    write_reg(qvr_pkg::REG_QUAT_Y, q.y);
    write_reg(qvr_pkg::REG_QUAT_Z, q.z);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lowers in_valid and waits on the clock first, so valid never drops and rises in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rot_expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_vec(input vec_t v, input bit typed, input rot_t want);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= v.x;
    in_vec_y <= v.y;
    in_vec_z <= v.z;
    do @(posedge clk); while (in_stall);
    queue_expected(typed ? want : rotate_vec(cur_quat, v));
  endtask

  always @(posedge clk) begin
    rot_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rot_expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat (%0d, %0d, %0d) with nothing outstanding",
                                  out_rot_x, out_rot_y, out_rot_z));
      end else begin
        want = rot_expected_q.pop_front();
        if (out_rot_x !== want.x)
          report_mismatch($sformatf("rot_x got %0d expected %0d", out_rot_x, want.x));
        if (out_rot_y !== want.y)
          report_mismatch($sformatf("rot_y got %0d expected %0d", out_rot_y, want.y));
        if (out_rot_z !== want.z)
          report_mismatch($sformatf("rot_z got %0d expected %0d", out_rot_z, want.z));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("saturated got %b expected %b", out_saturated,
                                    want.sat));
      end
    end
    out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    vec_t v;
    rot_t none;
    none = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run on the reset quaternion, so nothing is written before them.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].q != cur_quat) begin
        wait_drained();
        set_quat(directed_rows[i].q);
      end
      send_vec(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      set_quat(phase_quat(ph));
      idling_on = (ph != 3);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Let the pipeline empty completely once in mid stream.
        if (ph == 5 && n == PHASE_BEATS / 2) wait_drained();
        v.x = random_comp();
        v.y = random_comp();
        v.z = random_comp();
        send_vec(v, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (rot_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
